[src/tts_pkg.sv]
// shared types and constants for the trilinear tsdf sampler
// used by tts_ctrl, tts_datapath and the top level
package tts_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_MISSING = 2'd2,
    ST_NOCOVER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_VOX  = 3'd3,
    CFG_RES_X    = 3'd4,
    CFG_RES_Y    = 3'd5,
    CFG_RES_Z    = 3'd6,
    CFG_REQ_ALL  = 3'd7
  } cfg_idx_t;

  localparam int unsigned NUM_CFG = 8;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_GRID,
    S_CORNER,
    S_WMUL,
    S_ACC,
    S_CHECK,
    S_DIV,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic do_mul;
    logic do_grid;
    logic corner_rd;
    logic do_wmul;
    logic do_acc;
    logic mark_missing;
    logic div_start;
    logic div_step;
    logic set_result;
    logic [2:0] corner;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic is_write;
    logic outside;
    logic corner_fail;
    logic no_cover;
    logic div_done;
  } dp_stat_t;

endpackage

[src/tts_ctrl.sv]
// controller state machine of the sampler: clearing pass, corner walk, divide
// depends on tts_pkg
module tts_ctrl
  import tts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     req_all,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  logic [2:0] corner, corner_next;
  logic outv, outv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      corner <= '0;
      outv   <= 1'b0;
    end else begin
      state  <= state_next;
      corner <= corner_next;
      outv   <= outv_next;
    end
  end

  assign out_valid = outv;

  always_comb begin
    state_next  = state;
    corner_next = corner;
    outv_next   = outv && out_stall;
    cmd         = '0;
    cmd.corner  = corner;
    in_stall    = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.is_write) state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_GRID;
      end
      S_GRID: begin
        cmd.do_grid = 1'b1;
        corner_next = '0;
        state_next  = S_CORNER;
      end
      S_CORNER: begin
        if (stat.outside) begin
          state_next = S_OUT;
        end else begin
          cmd.corner_rd = 1'b1;
          state_next    = S_WMUL;
        end
      end
      S_WMUL: begin
        cmd.do_wmul = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        if (stat.corner_fail && req_all) begin
          cmd.mark_missing = 1'b1;
          state_next       = S_OUT;
        end else begin
          cmd.do_acc = 1'b1;
          corner_next = corner + 3'd1;
          state_next  = (corner == 3'd7) ? S_CHECK : S_CORNER;
        end
      end
      S_CHECK: begin
        if (stat.no_cover) begin
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!outv || !out_stall) begin
          cmd.set_result = 1'b1;
          outv_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/tts_datapath.sv]
// datapath of the sampler: voxel memory, grid mapping, corner blend, divider
// depends on tts_pkg
module tts_datapath
  import tts_pkg::*;
#(
  parameter int VOLUME_DIM = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               kind,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [4:0]         voxel_x,
  input  logic [4:0]         voxel_y,
  input  logic [4:0]         voxel_z,
  input  logic signed [15:0] voxel_distance,
  input  logic [15:0]        voxel_weight,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic [31:0]        inv_voxel_size,
  input  logic [5:0]         res_x,
  input  logic [5:0]         res_y,
  input  logic [5:0]         res_z,
  output logic [1:0]         status,
  output logic signed [15:0] distance
);

  localparam int AW    = $clog2(VOLUME_DIM);
  localparam int DEPTH = VOLUME_DIM * VOLUME_DIM * VOLUME_DIM;
  localparam int MA    = 3 * AW;
  localparam int FW    = FRAC_BITS + 1;
  localparam int CW    = 34 - FRAC_BITS + 32 + 2;
  localparam int WSW   = FW + 4;
  localparam int ACW   = WSW + 17;
  localparam int DB    = 16;
  localparam logic [WSW-1:0] MIN_WS = WSW'((64'd1 << FRAC_BITS) / 64'd1000000);
  localparam logic [FW-1:0] ONE = FW'(64'd1 << FRAC_BITS);
  localparam logic [5:0] DIM6 = (VOLUME_DIM > 32) ? 6'd32 : 6'(VOLUME_DIM);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd;

  // clearing pass
  logic [MA:0] clr_cnt;
  assign stat.clear_done = clr_cnt[MA];

  logic [MA-1:0] wr_addr, rd_addr;
  logic          wr_en;
  logic [31:0]   wr_data;

  logic wr_ok;
  assign wr_ok = ({1'b0, voxel_x} < 6'(VOLUME_DIM)) && ({1'b0, voxel_y} < 6'(VOLUME_DIM))
              && ({1'b0, voxel_z} < 6'(VOLUME_DIM));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt[MA-1:0];
    wr_data = '0;
    if (cmd.clear_step && !clr_cnt[MA]) begin
      wr_en = 1'b1;
    end else if (cmd.load && !kind && wr_ok) begin
      wr_en   = 1'b1;
      wr_addr = MA'((32'(voxel_z) * VOLUME_DIM + 32'(voxel_y)) * VOLUME_DIM + 32'(voxel_x));
      wr_data = {voxel_distance, voxel_weight};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear_step && !clr_cnt[MA]) clr_cnt <= clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  assign stat.is_write = !kind;

  // grid mapping, one 33x32 product per axis
  logic [32:0] mag [3];
  logic        neg [3];
  logic [64:0] prod [3];
  logic signed [CW-1:0] gbase [3];
  logic [FRAC_BITS-1:0] frac [3];
  logic [5:0] eres [3];
  logic out_r;
  logic signed [32:0] diff [3];

  always_comb begin
    diff[0] = 33'(point_x) - 33'(origin_x);
    diff[1] = 33'(point_y) - 33'(origin_y);
    diff[2] = 33'(point_z) - 33'(origin_z);
  end

  logic signed [32:0] d_r [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r[0] <= diff[0];
      d_r[1] <= diff[1];
      d_r[2] <= diff[2];
      eres[0] <= (res_x > DIM6) ? DIM6 : res_x;
      eres[1] <= (res_y > DIM6) ? DIM6 : res_y;
      eres[2] <= (res_z > DIM6) ? DIM6 : res_z;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k] = d_r[k][32];
      mag[k] = neg[k] ? 33'(-d_r[k]) : 33'(d_r[k]);
    end
  end

  logic neg_r [3];
  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      for (int k = 0; k < 3; k++) begin
        prod[k]  <= 65'(mag[k]) * 65'(inv_voxel_size);
        neg_r[k] <= neg[k];
      end
    end
  end

  logic signed [CW-1:0] lc [3];
  logic signed [CW-1:0] gc [3];
  logic outside_c;
  always_comb begin
    outside_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (neg_r[k])
        lc[k] = -CW'((prod[k] + 65'((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS);
      else
        lc[k] = CW'(prod[k] >> FRAC_BITS);
      if (lc[k] < 0 || lc[k] >= ($signed({1'b0, CW'(eres[k])}) <<< FRAC_BITS))
        outside_c = 1'b1;
      gc[k] = lc[k] - CW'(64'd1 << (FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_grid) begin
      out_r <= outside_c;
      for (int k = 0; k < 3; k++) begin
        gbase[k] <= gc[k] >>> FRAC_BITS;
        frac[k]  <= gc[k][FRAC_BITS-1:0];
      end
    end
  end
  assign stat.outside = out_r;

  // corner select
  logic signed [CW-1:0] cc [3];
  logic in_rng;
  logic [FW-1:0] wa [3];
  always_comb begin
    in_rng = 1'b1;
    for (int k = 0; k < 3; k++) begin
      cc[k] = gbase[k] + CW'(cmd.corner[k]);
      wa[k] = cmd.corner[k] ? FW'(frac[k]) : ONE - FW'(frac[k]);
      if (cc[k] < 0 || cc[k] >= $signed(CW'(eres[k]))) in_rng = 1'b0;
    end
    rd_addr = MA'((32'(cc[2][AW-1:0]) * VOLUME_DIM + 32'(cc[1][AW-1:0])) * VOLUME_DIM
                  + 32'(cc[0][AW-1:0]));
  end

  logic rng_r;
  logic [2*FW-1:0] wxy;
  logic [FW-1:0] wz_r;
  always_ff @(posedge clk) begin
    if (cmd.corner_rd) begin
      rng_r <= in_rng;
      wxy   <= (2*FW)'(wa[0]) * (2*FW)'(wa[1]);
      wz_r  <= wa[2];
    end
  end

  logic [FW-1:0] wcorner;
  logic signed [DB-1:0] dcorner;
  logic okc;
  always_ff @(posedge clk) begin
    if (cmd.do_wmul) begin
      wcorner <= FW'(((2*FW)'(wxy >> FRAC_BITS) * (2*FW)'(wz_r)) >> FRAC_BITS);
      dcorner <= rd[31:16];
      okc     <= rng_r && (rd[15:0] != 16'd0);
    end
  end
  assign stat.corner_fail = !okc;

  // set when a require-all sample hits a failing corner
  logic missing;
  always_ff @(posedge clk) begin
    if (cmd.do_grid) missing <= 1'b0;
    else if (cmd.mark_missing) missing <= 1'b1;
  end

  logic signed [ACW-1:0] acc;
  logic [WSW-1:0] ws;
  always_ff @(posedge clk) begin
    if (cmd.do_grid) begin
      acc <= '0;
      ws  <= '0;
    end else if (cmd.do_acc && okc) begin
      acc <= acc + ACW'($signed({1'b0, wcorner}) * dcorner);
      ws  <= ws + WSW'(wcorner);
    end
  end
  assign stat.no_cover = (ws <= MIN_WS);

  // restoring divider, one quotient bit per cycle
  localparam int NW = ACW;
  localparam int QN = $clog2(NW + 1);
  logic [NW-1:0] num;
  logic [NW:0]   rem;
  logic [QN-1:0] dcnt;
  logic          qneg;
  logic [NW:0]   trial;
  assign trial = {rem[NW-1:0], num[NW-1]} - (NW+1)'(ws);
  logic [NW-1:0] amag;
  assign amag = acc[ACW-1] ? NW'(-acc) : NW'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      num  <= amag + NW'(ws >> 1);
      rem  <= '0;
      qneg <= acc[ACW-1];
      dcnt <= QN'(NW);
    end else if (cmd.div_step && dcnt != '0) begin
      if (!trial[NW]) begin
        rem <= trial;
        num <= {num[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[NW-1:0], num[NW-1]};
        num <= {num[NW-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
  end
  assign stat.div_done = (dcnt == '0);

  logic signed [15:0] dsat;
  always_comb begin
    if (qneg) dsat = (num > NW'(32768)) ? 16'sh8000 : 16'(-num);
    else      dsat = (num > NW'(32767)) ? 16'sh7fff : 16'(num);
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      if (out_r) begin
        status <= ST_OUTSIDE; distance <= '0;
      end else if (missing) begin
        status <= ST_MISSING; distance <= '0;
      end else if (ws <= MIN_WS) begin
        status <= ST_NOCOVER; distance <= '0;
      end else begin
        status <= ST_OK; distance <= dsat;
      end
    end
  end

endmodule

[src/trilinear_tsdf_sampler.sv]
// channel   | handshake        | payload
// in        | in_valid/stall   | kind, point_*, voxel_*
// out       | out_valid/stall  | status, distance
// cfg       | cfg_valid/ready  | cfg_index, cfg_data
// a voxel write is taken in the idle state; a sample result is registered after grid
// mapping, a read, weight and accumulate step per corner for eight corners read serially
// from one port, coverage check, divider (one quotient bit a cycle, 38 bits) and output
// outside, missing-corner and no-coverage samples skip the rest and finish early
// after reset a clearing pass zeroes all VOLUME_DIM^3 voxels before items are taken
// a waiting result holds the next sample in the output state until out_stall drops
// depends on tts_pkg, tts_ctrl, tts_datapath
module trilinear_tsdf_sampler
  import tts_pkg::*;
#(
  parameter int VOLUME_DIM = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [4:0]         voxel_x,
  input  logic [4:0]         voxel_y,
  input  logic [4:0]         voxel_z,
  input  logic signed [15:0] voxel_distance,
  input  logic [15:0]        voxel_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [15:0] distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [31:0] inv_voxel_size;
  logic [5:0]  res_x, res_y, res_z;
  logic        req_all;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0; origin_y <= '0; origin_z <= '0;
      inv_voxel_size <= 32'd65536;
      res_x <= 6'd32; res_y <= 6'd32; res_z <= 6'd32;
      req_all <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        CFG_ORIGIN_Z: origin_z <= cfg_data;
        CFG_INV_VOX:  inv_voxel_size <= cfg_data;
        CFG_RES_X:    res_x <= cfg_data[5:0];
        CFG_RES_Y:    res_y <= cfg_data[5:0];
        CFG_RES_Z:    res_z <= cfg_data[5:0];
        CFG_REQ_ALL:  req_all <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tts_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .req_all, .stat, .cmd
  );

  tts_datapath #(.VOLUME_DIM(VOLUME_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .kind, .point_x, .point_y, .point_z,
    .voxel_x, .voxel_y, .voxel_z, .voxel_distance, .voxel_weight,
    .origin_x, .origin_y, .origin_z, .inv_voxel_size, .res_x, .res_y, .res_z,
    .status, .distance
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(distance))
    else $error("result changed under stall");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !cmd.div_step)
    else $error("input taken while dividing");
  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> distance == 16'sd0)
    else $error("failed sample with nonzero distance");

endmodule
